### rtl/hpvpm_pkg.sv
// ----------------------------------------------------------------------------
// hpvpm_pkg
// Shared types, register codes and helpers of the hashed page translation map.
// ----------------------------------------------------------------------------
package hpvpm_pkg;

  // address and field widths
  localparam int ADDR_W   = 64;
  localparam int TAG_W    = 16;
  localparam int INDEX_W  = 16;
  localparam int ENTRY_W  = TAG_W + INDEX_W;
  localparam int PAGE_SHIFT = 21;

  // register codes (paddr[4:3])
  localparam logic [1:0] REG_VA_BASE     = 2'd0;
  localparam logic [1:0] REG_BUCKET_MASK = 2'd1;
  localparam logic [1:0] REG_TAG_MASK    = 2'd2;

  // register reset values
  localparam logic [ADDR_W-1:0] VA_BASE_RST     = 64'd0;
  localparam logic [ADDR_W-1:0] BUCKET_MASK_RST = 64'h0000_0000_1FE0_0000;
  localparam logic [ADDR_W-1:0] TAG_MASK_RST    = 64'h0000_1FFF_E000_0000;

  // request kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // request held while its bucket row is read and updated
  typedef struct packed {
    logic                  kind;
    logic [PAGE_SHIFT-1:0] offset;
    logic [INDEX_W-1:0]    page_index;
    logic [TAG_W-1:0]      tag;
  } req_t;

  // position of the lowest set bit, zero for an empty mask (binary search)
  function automatic logic [5:0] lowbit(input logic [ADDR_W-1:0] m);
    logic [ADDR_W-1:0] x;
    logic [5:0]        s;
    x = m;
    s = '0;
    if (m != '0) begin
      for (int k = 5; k >= 0; k--) begin
        if ((x & ((64'd1 << (1 << k)) - 64'd1)) == '0) begin
          x = x >> (1 << k);
          s = s | 6'(1 << k);
        end
      end
    end
    return s;
  endfunction

endpackage

### rtl/hpvpm_ram.sv
// ----------------------------------------------------------------------------
// hpvpm_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module hpvpm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/hashed_phys_to_virt_page_map_top.sv
// ----------------------------------------------------------------------------
// hashed_phys_to_virt_page_map_top
// Physical to virtual translation for 2 MiB pages in a set-associative table.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  in      | input     | in_valid / in_stall     | kind, phys_addr, page_index
//  out     | output    | out_valid / out_stall   | virt_addr, found, bucket_full
//  cfg     | input     | psel, penable, pwrite   | paddr, pwdata, prdata, pready
//
//  One request at a time: accept, row read, update and result. When BUCKETS is not
//  a power of two, the bucket remainder (fold, quotient, correction) comes before the
//  read. After reset a clearing pass writes every bucket row empty, with in_stall
//  high; register writes are taken during it.
//  A result waits in the output register while out_stall is high; the next
//  request is accepted meanwhile and finishes once the output register frees.
//
module hashed_phys_to_virt_page_map_top #(
  parameter int BUCKETS = 256,
  parameter int WAYS    = 4
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [63:0] phys_addr,
  input  logic [15:0] page_index,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] virt_addr,
  output logic        found,
  output logic        bucket_full,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int  BW        = $clog2(BUCKETS);
  localparam int  CNT_W     = $clog2(WAYS + 1);
  localparam int  ROW_W     = WAYS * hpvpm_pkg::ENTRY_W + CNT_W;
  localparam bit  POW2      = ((BUCKETS & (BUCKETS - 1)) == 0);
  localparam int  MOD_CYC   = 3;
  localparam int  MC_W      = $clog2(MOD_CYC);

  // weights of the upper 16-bit chunks modulo BUCKETS, and the reciprocal
  localparam logic [15:0] CK1   = 16'((64'd1 << 16) % 64'(BUCKETS));
  localparam logic [15:0] CK2   = 16'((64'd1 << 32) % 64'(BUCKETS));
  localparam logic [15:0] CK3   = 16'((64'd1 << 48) % 64'(BUCKETS));
  localparam logic [16:0] BK    = 17'(BUCKETS);
  localparam logic [33:0] RECIP = 34'((64'd1 << 34) / 64'(BUCKETS));

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_EXEC  = 3'd4;

  logic [2:0]        state;
  logic [BW-1:0]     clr_addr;
  logic [BW-1:0]     bucket;
  hpvpm_pkg::req_t   req;

  logic [63:0]       va_base;
  logic [63:0]       bucket_mask;
  logic [63:0]       tag_mask;
  logic [5:0]        bshift;
  logic [5:0]        tshift;

  logic [63:0]       mod_src;
  logic [MC_W-1:0]   mod_cnt;
  logic [31:0]       fold_p1;
  logic [31:0]       fold_p2;
  logic [31:0]       fold_p3;
  logic [33:0]       fold_sum;
  logic [33:0]       fold;
  logic [17:0]       quot_est;
  logic [17:0]       quot;
  logic [33:0]       quot_back;
  logic [33:0]       rem_wide;
  logic [BW-1:0]     rem_fix;

  logic              ram_we;
  logic [BW-1:0]     ram_waddr;
  logic [ROW_W-1:0]  ram_wdata;
  logic [ROW_W-1:0]  row;
  logic [ROW_W-1:0]  row_next;

  logic [63:0]       bsel;
  logic [63:0]       tsel;
  logic              accept;
  logic              cfg_write;
  logic              out_free;
  logic              finish;

  logic              hit;
  logic              full;
  logic [hpvpm_pkg::INDEX_W-1:0] hit_index;
  logic [63:0]       va;

  assign pready    = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_write = psel && penable && pwrite;
  assign out_free  = !out_valid || !out_stall;
  assign finish    = (state == S_EXEC) && out_free;

  // bucket and tag fields of the incoming address
  assign bsel = (phys_addr & bucket_mask) >> bshift;
  assign tsel = (phys_addr & tag_mask) >> tshift;

  // register read-back
  always_comb begin
    unique case (paddr[4:3])
      hpvpm_pkg::REG_VA_BASE:     prdata = va_base;
      hpvpm_pkg::REG_BUCKET_MASK: prdata = bucket_mask;
      hpvpm_pkg::REG_TAG_MASK:    prdata = tag_mask;
      default:                    prdata = '0;
    endcase
  end

  // configuration registers, shift amounts follow the written mask
  always_ff @(posedge clk) begin
    if (rst) begin
      va_base     <= hpvpm_pkg::VA_BASE_RST;
      bucket_mask <= hpvpm_pkg::BUCKET_MASK_RST;
      tag_mask    <= hpvpm_pkg::TAG_MASK_RST;
      bshift      <= hpvpm_pkg::lowbit(hpvpm_pkg::BUCKET_MASK_RST);
      tshift      <= hpvpm_pkg::lowbit(hpvpm_pkg::TAG_MASK_RST);
    end else if (cfg_write) begin
      unique case (paddr[4:3])
        hpvpm_pkg::REG_VA_BASE: begin
          va_base <= pwdata;
        end
        hpvpm_pkg::REG_BUCKET_MASK: begin
          bucket_mask <= pwdata;
          bshift      <= hpvpm_pkg::lowbit(pwdata);
        end
        hpvpm_pkg::REG_TAG_MASK: begin
          tag_mask <= pwdata;
          tshift   <= hpvpm_pkg::lowbit(pwdata);
        end
        default: begin
        end
      endcase
    end
  end

  // remainder by BUCKETS: fold 16-bit chunks by their weights, then
  // reciprocal quotient estimate (low by at most one) and one correction
  assign fold_p1   = 32'(mod_src[31:16]) * 32'(CK1);
  assign fold_p2   = 32'(mod_src[47:32]) * 32'(CK2);
  assign fold_p3   = 32'(mod_src[63:48]) * 32'(CK3);
  assign fold_sum  = 34'(mod_src[15:0]) + 34'(fold_p1) + 34'(fold_p2) + 34'(fold_p3);
  assign quot_est  = 18'((68'(fold) * 68'(RECIP)) >> 34);
  assign quot_back = 34'(quot) * 34'(BK);
  assign rem_wide  = fold - quot_back;
  assign rem_fix   = (rem_wide >= 34'(BK)) ? BW'(rem_wide - 34'(BK)) : BW'(rem_wide);

  // lookup match and insert update on the bucket row
  always_comb begin : row_update
    logic [CNT_W-1:0]             cnt;
    logic [hpvpm_pkg::ENTRY_W-1:0] e;
    cnt       = row[WAYS*hpvpm_pkg::ENTRY_W +: CNT_W];
    hit       = 1'b0;
    hit_index = '0;
    row_next  = row;
    // ways below the fill count are the valid ones, first match wins
    for (int w = 0; w < WAYS; w++) begin
      e = row[w*hpvpm_pkg::ENTRY_W +: hpvpm_pkg::ENTRY_W];
      if (!hit && (CNT_W'(w) < cnt) && (e[hpvpm_pkg::ENTRY_W-1 -: hpvpm_pkg::TAG_W] == req.tag))
      begin
        hit       = 1'b1;
        hit_index = e[hpvpm_pkg::INDEX_W-1:0];
      end
    end
    // insert goes to the first free way
    full = (cnt == CNT_W'(WAYS));
    for (int w = 0; w < WAYS; w++) begin
      if (CNT_W'(w) == cnt) begin
        row_next[w*hpvpm_pkg::ENTRY_W +: hpvpm_pkg::ENTRY_W] = {req.tag, req.page_index};
      end
    end
    row_next[WAYS*hpvpm_pkg::ENTRY_W +: CNT_W] = cnt + CNT_W'(1);
  end

  // translated address, index and page offset occupy disjoint bits
  assign va = va_base + {{(64 - hpvpm_pkg::INDEX_W - hpvpm_pkg::PAGE_SHIFT){1'b0}},
                         hit_index, req.offset};

  // memory write port: clearing pass or insert write-back
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = bucket;
    ram_wdata = row_next;
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (finish && (req.kind == hpvpm_pkg::KIND_INSERT) && !full) begin
      ram_we = 1'b1;
    end
  end

  hpvpm_ram #(
    .WIDTH (ROW_W),
    .DEPTH (BUCKETS)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (state == S_READ),
    .raddr (bucket),
    .rdata (row)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      mod_cnt  <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + BW'(1);
          if (clr_addr == BW'(BUCKETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            mod_cnt <= '0;
            state   <= POW2 ? S_READ : S_MOD;
          end
        end
        S_MOD: begin
          mod_cnt <= mod_cnt + MC_W'(1);
          if (mod_cnt == MC_W'(MOD_CYC - 1)) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // request capture and bucket number
  always_ff @(posedge clk) begin
    if (accept) begin
      req.kind       <= kind;
      req.offset     <= phys_addr[hpvpm_pkg::PAGE_SHIFT-1:0];
      req.page_index <= page_index;
      req.tag        <= tsel[hpvpm_pkg::TAG_W-1:0];
      bucket         <= bsel[BW-1:0];
      mod_src        <= bsel;
    end else if (state == S_MOD) begin
      if (mod_cnt == MC_W'(0)) begin
        fold <= fold_sum;
      end
      if (mod_cnt == MC_W'(1)) begin
        quot <= quot_est;
      end
      if (mod_cnt == MC_W'(MOD_CYC - 1)) begin
        bucket <= rem_fix;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      if (req.kind == hpvpm_pkg::KIND_INSERT) begin
        virt_addr   <= '0;
        found       <= 1'b0;
        bucket_full <= full;
      end else begin
        virt_addr   <= hit ? va : '0;
        found       <= hit;
        bucket_full <= 1'b0;
      end
    end
  end

endmodule
